// ===== src/bti_pkg.sv =====
// Shared definitions for the bilinear table interpolator: default sizes,
// register and action codes, and the write control word of the sample store.
// No dependencies.
package bti_pkg;

  localparam int MAX_COLUMNS_DEF         = 32;
  localparam int MAX_ROWS_DEF            = 32;
  localparam int COORD_FRACTION_BITS_DEF = 16;
  localparam int SAMPLE_BITS_DEF         = 16;

  // Size registers are six bits wide and come out of reset at 32.
  localparam int              CFG_BITS  = 6;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 6'd32;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_index_t;

  localparam logic ACTION_LOOKUP = 1'b0;
  localparam logic ACTION_WRITE  = 1'b1;

  // Bank number is {row parity, column parity}.
  typedef struct packed {
    logic       en;
    logic [1:0] bank;
  } bti_wr_ctl_t;

endpackage

// ===== src/bti_store.sv =====
// Sample store split into four banks by column and row parity, so the four
// corners of a cell are read in parallel. Uses bti_pkg for the write control word.
module bti_store #(
  parameter int SAMPLE_BITS = bti_pkg::SAMPLE_BITS_DEF,
  parameter int ADDR_BITS   = 8
) (
  input  logic                              clk,
  input  bti_pkg::bti_wr_ctl_t              wr_ctl,
  input  logic [ADDR_BITS-1:0]              wr_addr,
  input  logic [SAMPLE_BITS-1:0]            wr_data,
  input  logic                              rd_en,
  input  logic [3:0][ADDR_BITS-1:0]         rd_addr,
  output logic [3:0][SAMPLE_BITS-1:0]       rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] q;

    always_ff @(posedge clk) begin
      if (wr_ctl.en && (wr_ctl.bank == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      // The read register holds its word while the stage after it is stalled.
      if (rd_en) begin
        q <= mem[rd_addr[b]];
      end
    end

    assign rd_data[b] = q;
  end

endmodule

// ===== src/bilinear_table_interpolator.sv =====
// Bilinear table interpolator: eight-stage pipeline, one word accepted per cycle
// while in_ready is high. A lookup result passes stages 1 to 8 to the output register;
// sample writes take effect in stage 3 and produce no result.
// Throughput is one word per cycle without output stalls, set by the four parity banks.
// Synchronous reset empties the pipeline and sets both size registers to 32; the
// sample store is not cleared. Depends on bti_pkg and bti_store.
module bilinear_table_interpolator #(
  parameter int MAX_COLUMNS         = bti_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS            = bti_pkg::MAX_ROWS_DEF,
  parameter int COORD_FRACTION_BITS = bti_pkg::COORD_FRACTION_BITS_DEF,
  parameter int SAMPLE_BITS         = bti_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bti_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [bti_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [bti_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic signed [COORD_FRACTION_BITS+1:0] x_coord,
  input  logic signed [COORD_FRACTION_BITS+1:0] y_coord,
  input  logic [$clog2(MAX_COLUMNS)-1:0]        write_column,
  input  logic [$clog2(MAX_ROWS)-1:0]           write_row,
  input  logic signed [SAMPLE_BITS-1:0]         write_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         interpolated_value
);

  localparam int F        = COORD_FRACTION_BITS;
  localparam int SB       = SAMPLE_BITS;
  localparam int CB       = bti_pkg::CFG_BITS;
  localparam int COL_BITS = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS = $clog2(MAX_ROWS);
  localparam int CHW      = (COL_BITS > 1) ? COL_BITS - 1 : 1;
  localparam int RHW      = (ROW_BITS > 1) ? ROW_BITS - 1 : 1;
  localparam int AW       = CHW + RHW;
  localparam int SW       = F + 1 + CB;
  localparam int IW       = SW - F;
  localparam int BW       = SB + F;
  localparam int NS       = 8;
  localparam int COLS_CAP = (MAX_COLUMNS < (2**CB) - 1) ? MAX_COLUMNS : (2**CB) - 1;
  localparam int ROWS_CAP = (MAX_ROWS < (2**CB) - 1) ? MAX_ROWS : (2**CB) - 1;
  localparam logic [2*F:0] QHALF = {2'b01, {(2*F-1){1'b0}}};

  // ---------------------------------------------------------------- registers
  logic [CB-1:0] columns_in_use;
  logic [CB-1:0] rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= bti_pkg::CFG_RESET;
      rows_in_use    <= bti_pkg::CFG_RESET;
    end else if (psel && penable && pwrite) begin
      case (bti_pkg::reg_index_t'(paddr[2]))
        bti_pkg::REG_COLUMNS: columns_in_use <= pwdata[CB-1:0];
        bti_pkg::REG_ROWS:    rows_in_use    <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (bti_pkg::reg_index_t'(paddr[2]))
      bti_pkg::REG_COLUMNS: prdata[CB-1:0] = columns_in_use;
      bti_pkg::REG_ROWS:    prdata[CB-1:0] = rows_in_use;
      default: ;
    endcase
  end

  assign pready = 1'b1;

  // A size of zero acts as one, and a size above the table acts as the table size.
  logic [CB-1:0] cols_eff, rows_eff, cols_m1, rows_m1;

  always_comb begin
    cols_eff = columns_in_use;
    if (cols_eff == '0) begin
      cols_eff = CB'(1);
    end else if (cols_eff > CB'(COLS_CAP)) begin
      cols_eff = CB'(COLS_CAP);
    end
    rows_eff = rows_in_use;
    if (rows_eff == '0) begin
      rows_eff = CB'(1);
    end else if (rows_eff > CB'(ROWS_CAP)) begin
      rows_eff = CB'(ROWS_CAP);
    end
    cols_m1 = cols_eff - CB'(1);
    rows_m1 = rows_eff - CB'(1);
  end

  // ---------------------------------------------------------- pipeline control
  logic [NS:1]   v;
  logic [NS+1:1] rdy;
  logic          act3;

  always_comb begin
    rdy[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  // Write words leave the pipeline once they have reached the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3] && (act3 == bti_pkg::ACTION_LOOKUP);
      if (rdy[5]) v[5] <= v[4];
      if (rdy[6]) v[6] <= v[5];
      if (rdy[7]) v[7] <= v[6];
      if (rdy[8]) v[8] <= v[7];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[NS];

  // ------------------------------------------------- stage 1: clamp below zero
  logic                act1;
  logic [F:0]          xc1, yc1;
  logic [COL_BITS-1:0] wcol1;
  logic [ROW_BITS-1:0] wrow1;
  logic [SB-1:0]       wsamp1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      act1   <= action;
      xc1    <= x_coord[F+1] ? '0 : x_coord[F:0];
      yc1    <= y_coord[F+1] ? '0 : y_coord[F:0];
      wcol1  <= write_column;
      wrow1  <= write_row;
      wsamp1 <= write_sample;
    end
  end

  // ------------------------------------------------------ stage 2: scale axes
  logic                act2;
  logic [SW-1:0]       sx2, sy2;
  logic [COL_BITS-1:0] wcol2;
  logic [ROW_BITS-1:0] wrow2;
  logic [SB-1:0]       wsamp2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      act2   <= act1;
      sx2    <= SW'(xc1) * SW'(cols_m1);
      sy2    <= SW'(yc1) * SW'(rows_m1);
      wcol2  <= wcol1;
      wrow2  <= wrow1;
      wsamp2 <= wsamp1;
    end
  end

  // ------------------------------------------- stage 3: cell index and weight
  logic [IW-1:0]       ipx, ipy;
  logic [COL_BITS-1:0] x0_3;
  logic [ROW_BITS-1:0] y0_3;
  logic [F-1:0]        tx3, ty3;
  logic                xcl3, ycl3;
  logic [COL_BITS-1:0] wcol3;
  logic [ROW_BITS-1:0] wrow3;
  logic [SB-1:0]       wsamp3;

  assign ipx = sx2[SW-1:F];
  assign ipy = sy2[SW-1:F];

  // At or past the last column or row the cell collapses onto it with zero weight.
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      act3   <= act2;
      wcol3  <= wcol2;
      wrow3  <= wrow2;
      wsamp3 <= wsamp2;
      if (ipx >= {1'b0, cols_m1}) begin
        x0_3 <= COL_BITS'(cols_m1);
        tx3  <= '0;
        xcl3 <= 1'b1;
      end else begin
        x0_3 <= COL_BITS'(ipx);
        tx3  <= sx2[F-1:0];
        xcl3 <= 1'b0;
      end
      if (ipy >= {1'b0, rows_m1}) begin
        y0_3 <= ROW_BITS'(rows_m1);
        ty3  <= '0;
        ycl3 <= 1'b1;
      end else begin
        y0_3 <= ROW_BITS'(ipy);
        ty3  <= sy2[F-1:0];
        ycl3 <= 1'b0;
      end
    end
  end

  // ------------------------------------------------ stage 4: sample store access
  bti_pkg::bti_wr_ctl_t         wr_ctl;
  logic [AW-1:0]                wr_addr;
  logic [3:0][AW-1:0]           rd_addr;
  logic [3:0][SB-1:0]           rd_data;
  logic                         wr_in_range;
  logic [COL_BITS:0]            x0p1;
  logic [ROW_BITS:0]            y0p1;
  logic [CHW-1:0]               col_even, col_odd;
  logic [RHW-1:0]               row_even, row_odd;

  assign wr_in_range = ({1'b0, wcol3} < (COL_BITS+1)'(MAX_COLUMNS)) &&
                       ({1'b0, wrow3} < (ROW_BITS+1)'(MAX_ROWS));
  assign wr_ctl.en   = v[3] && (act3 == bti_pkg::ACTION_WRITE) && rdy[4] && wr_in_range;
  assign wr_ctl.bank = {wrow3[0], wcol3[0]};
  assign wr_addr     = {RHW'(wrow3 >> 1), CHW'(wcol3 >> 1)};

  // Of the two neighboring columns, the even one sits at (x0+1)/2 and the odd one at x0/2.
  assign x0p1     = {1'b0, x0_3} + (COL_BITS+1)'(1);
  assign y0p1     = {1'b0, y0_3} + (ROW_BITS+1)'(1);
  assign col_even = CHW'(x0p1 >> 1);
  assign col_odd  = CHW'(x0_3 >> 1);
  assign row_even = RHW'(y0p1 >> 1);
  assign row_odd  = RHW'(y0_3 >> 1);

  assign rd_addr[0] = {row_even, col_even};
  assign rd_addr[1] = {row_even, col_odd};
  assign rd_addr[2] = {row_odd,  col_even};
  assign rd_addr[3] = {row_odd,  col_odd};

  bti_store #(
    .SAMPLE_BITS (SB),
    .ADDR_BITS   (AW)
  ) u_store (
    .clk     (clk),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_data (wsamp3),
    .rd_en   (rdy[4]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [F-1:0] tx4, ty4;
  logic         xp4, yp4, xcl4, ycl4;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      tx4  <= tx3;
      ty4  <= ty3;
      xp4  <= x0_3[0];
      yp4  <= y0_3[0];
      xcl4 <= xcl3;
      ycl4 <= ycl3;
    end
  end

  // ------------------------------------------------ stage 5: horizontal blends
  logic signed [SB-1:0]   ca, cb, cc, cd, b_raw, c_raw, d_raw, d_mid;
  logic signed [SB:0]     dba, ddc;
  logic signed [BW+1:0]   prod_top, prod_bot, top_full, bot_full;
  logic signed [BW-1:0]   top5, bot5;
  logic [F-1:0]           ty5;

  // A collapsed axis takes its second corner from the first, so a neighbor
  // outside the written area never reaches the arithmetic.
  always_comb begin
    ca    = rd_data[{yp4, xp4}];
    b_raw = rd_data[{yp4, ~xp4}];
    c_raw = rd_data[{~yp4, xp4}];
    d_raw = rd_data[{~yp4, ~xp4}];
    cb    = xcl4 ? ca : b_raw;
    d_mid = xcl4 ? c_raw : d_raw;
    cc    = ycl4 ? ca : c_raw;
    cd    = ycl4 ? cb : d_mid;
    dba      = $signed({cb[SB-1], cb}) - $signed({ca[SB-1], ca});
    ddc      = $signed({cd[SB-1], cd}) - $signed({cc[SB-1], cc});
    prod_top = dba * $signed({1'b0, tx4});
    prod_bot = ddc * $signed({1'b0, tx4});
    top_full = $signed({{2{ca[SB-1]}}, ca, {F{1'b0}}}) + prod_top;
    bot_full = $signed({{2{cc[SB-1]}}, cc, {F{1'b0}}}) + prod_bot;
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      top5 <= top_full[BW-1:0];
      bot5 <= bot_full[BW-1:0];
      ty5  <= ty4;
    end
  end

  // ------------------------------------------------ stage 6: vertical difference
  logic signed [BW:0]   diff6;
  logic signed [BW-1:0] top6;
  logic [F-1:0]         ty6;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      diff6 <= $signed({bot5[BW-1], bot5}) - $signed({top5[BW-1], top5});
      top6  <= top5;
      ty6   <= ty5;
    end
  end

  // ------------------------------------------- stage 7: vertical weight products
  logic signed [SB:0]   dh;
  logic [F-1:0]         dl;
  logic [2*F:0]         ql;
  logic signed [BW+1:0] pm7;
  logic [F:0]           qh7;
  logic signed [BW-1:0] top7;

  // The difference is split at the binary point; the low part carries the rounding half.
  assign dh = diff6[BW:F];
  assign dl = diff6[F-1:0];
  assign ql = (2*F+1)'(dl) * (2*F+1)'(ty6) + QHALF;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      pm7  <= dh * $signed({1'b0, ty6});
      qh7  <= ql[2*F:F];
      top7 <= top6;
    end
  end

  // --------------------------------------------------- stage 8: sum and round
  logic signed [BW+1:0] psum;

  assign psum = $signed({{2{top7[BW-1]}}, top7}) + pm7 +
                $signed({{(BW+1-F){1'b0}}, qh7});

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      interpolated_value <= psum[F+SB-1:F];
    end
  end

  // ---------------------------------------------------------------- assertions
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output word valid right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled although the output is moving");

  a_rise_from_stage7: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v[7]))
    else $error("output word appeared without a word in stage 7");

  a_collapsed_weight: assert property (@(posedge clk) disable iff (rst)
    (v[3] && (xcl3 || ycl3)) |-> ((!xcl3 || tx3 == '0) && (!ycl3 || ty3 == '0)))
    else $error("collapsed axis carries a nonzero weight");

endmodule
